>>> design/csvs_pkg.sv
// Shared types and byte constants for the CSV field splitter.
package csvs_pkg;

  localparam logic [7:0] CHR_QUOTE = 8'h22;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_TAB = 8'h09;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_CR = 8'h0D;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_LEADING = 1'b1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] field_byte;
    logic       byte_valid;
    logic       field_done;
    logic       line_done;
    logic [7:0] field_number;
  } out_item_t;

endpackage

>>> design/csvs_in_if.sv
// Request channel carrying line bytes into the CSV field splitter.
interface csvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       line_last;

  modport source (output valid, output text_byte, output line_last, input ready);
  modport sink (input valid, input text_byte, input line_last, output ready);
endinterface

>>> design/csvs_out_if.sv
// Result channel carrying field content out of the CSV field splitter.
interface csvs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] field_byte;
  logic       byte_valid;
  logic       field_done;
  logic       line_done;
  logic [7:0] field_number;

  modport source (
    output valid, output field_byte, output byte_valid, output field_done,
    output line_done, output field_number, input ready
  );
  modport sink (
    input valid, input field_byte, input byte_valid, input field_done,
    input line_done, input field_number, output ready
  );
endinterface

>>> design/csv_field_splitter_top.sv
// CSV field splitter top level: parser state and four-entry result queue.
//
// Takes one byte of a text line per request and streams the unquoted field
// content, with field and line end marks and the field number. A request
// causes zero, one or two results; the parser state advances in the cycle a
// request is accepted and its results go straight into a four-entry result
// queue. A request is taken whenever the queue has room for two results, so
// the block accepts one byte per cycle while the sink keeps up; the queue
// absorbs the second result of a request that makes two. Results are
// registered in the queue before they reach the output. Configuration writes
// (tab mode, leading whitespace trim) take effect on the next request.
module csv_field_splitter_top
  import csvs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  csvs_in_if.sink              in_i,
  csvs_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic                 cfg_wdata_i
);

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_PLAIN = 3'd1;
  localparam logic [2:0] PH_QUOTED = 3'd2;
  localparam logic [2:0] PH_QQ = 3'd3;
  localparam logic [2:0] PH_BS = 3'd4;
  localparam logic [2:0] PH_BSQ = 3'd5;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  logic            tab_mode_q, trim_q;
  logic [2:0]      phase_q, phase_d;
  logic [7:0]      fcount_q, fcount_d;
  logic            sl_q, sl_d;
  logic [QCNT_W-1:0] count_q, count_d;
  out_item_t       slot_q [QDEPTH];
  out_item_t       slot_d [QDEPTH];

  logic            acc, pop;
  in_item_t        req;
  logic [7:0]      sep;
  logic [2:0]      ph_n;
  logic            fend;
  logic [1:0]      npend;
  logic [7:0]      p0, p1;
  logic            keep0, keep1, sl1;
  logic            w0, w1;
  out_item_t       r0, r1, push_a, push_b;
  logic [1:0]      npush;
  logic [QCNT_W-1:0] base;

  function automatic logic is_ws(logic [7:0] b);
    return (b == CHR_SPACE) || (b >= CHR_TAB && b <= CHR_CR);
  endfunction

  assign req.text_byte = in_i.text_byte;
  assign req.line_last = in_i.line_last;
  assign in_i.ready = (count_q <= QCNT_W'(QDEPTH - 2));
  assign acc = in_i.valid && in_i.ready;
  assign out_o.valid = (count_q != '0);
  assign pop = out_o.valid && out_o.ready;
  assign out_o.field_byte = slot_q[0].field_byte;
  assign out_o.byte_valid = slot_q[0].byte_valid;
  assign out_o.field_done = slot_q[0].field_done;
  assign out_o.line_done = slot_q[0].line_done;
  assign out_o.field_number = slot_q[0].field_number;

  assign sep = tab_mode_q ? CHR_TAB : CHR_COMMA;

  // Parse one byte
  always_comb begin
    ph_n = phase_q;
    fend = 1'b0;
    npend = 2'd0;
    p0 = req.text_byte;
    p1 = req.text_byte;
    unique case (phase_q)
      PH_PLAIN: begin
        if (req.text_byte == sep) begin
          fend = 1'b1;
        end else begin
          npend = 2'd1;
        end
      end
      PH_QUOTED: begin
        if (req.text_byte == CHR_QUOTE) begin
          ph_n = PH_QQ;
        end else if (req.text_byte == CHR_BSLASH) begin
          ph_n = PH_BS;
        end else begin
          npend = 2'd1;
        end
      end
      PH_QQ: begin
        if (req.text_byte == CHR_QUOTE) begin
          npend = 2'd1;
          ph_n = PH_QUOTED;
        end else begin
          fend = 1'b1;
        end
      end
      PH_BS: begin
        if (req.text_byte == CHR_QUOTE) begin
          ph_n = PH_BSQ;
        end else if (req.text_byte == CHR_BSLASH) begin
          npend = 2'd1;
          p0 = CHR_BSLASH;
        end else begin
          npend = 2'd2;
          p0 = CHR_BSLASH;
          ph_n = PH_QUOTED;
        end
      end
      PH_BSQ: begin
        p0 = CHR_QUOTE;
        ph_n = PH_QUOTED;
        if (req.text_byte == CHR_QUOTE) begin
          npend = 2'd2;
          p0 = CHR_BSLASH;
          p1 = CHR_QUOTE;
        end else if (req.text_byte == CHR_BSLASH) begin
          npend = 2'd1;
          ph_n = PH_BS;
        end else begin
          npend = 2'd2;
        end
      end
      default: begin
        if (!tab_mode_q && req.text_byte == CHR_QUOTE) begin
          ph_n = PH_QUOTED;
        end else if (req.text_byte == sep) begin
          fend = 1'b1;
        end else begin
          npend = 2'd1;
          ph_n = PH_PLAIN;
        end
      end
    endcase

    // Flush a held escape at line end
    if (req.line_last) begin
      if (ph_n == PH_BS || ph_n == PH_BSQ) begin
        if (npend == 2'd0) begin
          p0 = (ph_n == PH_BS) ? CHR_BSLASH : CHR_QUOTE;
          npend = 2'd1;
        end else if (npend == 2'd1) begin
          p1 = (ph_n == PH_BS) ? CHR_BSLASH : CHR_QUOTE;
          npend = 2'd2;
        end
      end
      fend = 1'b1;
    end
  end

  // Form results
  always_comb begin
    keep0 = !(trim_q && sl_q && is_ws(p0));
    sl1 = sl_q && !keep0;
    keep1 = !(trim_q && sl1 && is_ws(p1));
    r0 = '0;
    r1 = '0;
    r0.field_number = fcount_q;
    r1.field_number = fcount_q;
    w0 = 1'b0;
    w1 = 1'b0;
    sl_d = sl_q;
    unique case (npend)
      2'd1: begin
        w0 = keep0 || fend || req.line_last;
        r0.byte_valid = keep0;
        r0.field_byte = keep0 ? p0 : 8'h00;
        r0.field_done = fend;
        r0.line_done = req.line_last;
        sl_d = sl1;
      end
      2'd2: begin
        w0 = keep0;
        r0.byte_valid = keep0;
        r0.field_byte = keep0 ? p0 : 8'h00;
        w1 = keep1 || fend || req.line_last;
        r1.byte_valid = keep1;
        r1.field_byte = keep1 ? p1 : 8'h00;
        r1.field_done = fend;
        r1.line_done = req.line_last;
        sl_d = sl1 && !keep1;
      end
      default: begin
        w0 = fend || req.line_last;
        r0.field_done = fend;
        r0.line_done = req.line_last;
      end
    endcase

    phase_d = ph_n;
    fcount_d = fcount_q;
    if (fend) begin
      phase_d = PH_START;
      sl_d = 1'b1;
      if (fcount_q != 8'hFF) begin
        fcount_d = fcount_q + 8'd1;
      end
    end
    if (req.line_last) begin
      phase_d = PH_START;
      sl_d = 1'b1;
      fcount_d = 8'd0;
    end
  end

  // Result queue: shift on pop, append after the remaining entries
  always_comb begin
    push_a = w0 ? r0 : r1;
    push_b = r1;
    npush = acc ? (2'(w0) + 2'(w1)) : 2'd0;
    base = count_q - QCNT_W'(pop);
    count_d = base + QCNT_W'(npush);
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        slot_d[i] = slot_q[i+1];
      end else begin
        slot_d[i] = slot_q[i];
      end
      if (npush != 2'd0 && base == QCNT_W'(i)) begin
        slot_d[i] = push_a;
      end
      if (npush == 2'd2 && base + QCNT_W'(1) == QCNT_W'(i)) begin
        slot_d[i] = push_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_mode_q <= 1'b0;
      trim_q <= 1'b0;
      phase_q <= PH_START;
      fcount_q <= 8'd0;
      sl_q <= 1'b1;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TAB_MODE: tab_mode_q <= cfg_wdata_i;
          CFG_TRIM_LEADING: trim_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (acc) begin
        phase_q <= phase_d;
        fcount_q <= fcount_d;
        sl_q <= sl_d;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDEPTH; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_BSQ)
    else $error("parser phase out of range");

  a_line_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && req.line_last) |=> (fcount_q == 8'd0 && sl_q && phase_q == PH_START))
    else $error("line end did not clear parser state");

  a_line_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && req.line_last) |=> (count_q != '0))
    else $error("line end produced no result");
`endif

endmodule
